FILE: sv/wpr_pkg.sv
// ----------------------------------------------------------------------------
// wpr_pkg
// Types, constants and codes shared by the Williams %R block.
// ----------------------------------------------------------------------------
`default_nettype none

package wpr_pkg;

  localparam int MAX_PERIOD_DEF = 1024;
  localparam int PRICE_BITS_DEF = 32;

  localparam int FIELD_BITS = 32;
  localparam int Q_BITS     = 15;
  localparam int FULL_SCALE = 25600;

  localparam int PERIOD_W = 11;
  localparam int SHIFT_W  = 6;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd14;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 6'd40;
  localparam logic signed [15:0]  PCT_MIN      = -16'sd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_PERIOD = 1'd0,
    CFG_FLAT_SHIFT    = 1'd1
  } wpr_cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_FIX  = 7'b0000100,
    ST_CALC = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } wpr_state_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] high_price;
    logic [FIELD_BITS-1:0] low_price;
    logic [FIELD_BITS-1:0] close_price;
    logic                  emit_enable;
    logic                  last_bar;
  } wpr_in_t;

  typedef struct packed {
    logic signed [15:0]    percent_r;
    logic                  flat_window;
    logic [FIELD_BITS-1:0] bar_index;
  } wpr_out_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [Q_BITS-1:0] quotient;
  } wpr_div_stat_t;

endpackage

`default_nettype wire

FILE: sv/wpr_window_mem.sv
// ----------------------------------------------------------------------------
// wpr_window_mem
// Ring memory holding the high and low of each bar, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wpr_window_mem import wpr_pkg::*; #(
  parameter int DEPTH  = MAX_PERIOD_DEF,
  parameter int ADDR_W = $clog2(MAX_PERIOD_DEF),
  parameter int DATA_W = 2 * PRICE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/wpr_divider.sv
// ----------------------------------------------------------------------------
// wpr_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the upper part of the numerator is below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module wpr_divider import wpr_pkg::*; #(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [PRICE_BITS+Q_BITS-1:0] num,
  input  wire logic [PRICE_BITS-1:0]        den,
  output wpr_div_stat_t                     stat
);

  localparam int CNT_W = $clog2(Q_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PRICE_BITS-1:0] rem_r, rem_nxt;
  logic [PRICE_BITS-1:0] den_r, den_nxt;
  logic [Q_BITS-1:0]     dq_r, dq_nxt;
  logic [PRICE_BITS:0]   trial;
  logic [PRICE_BITS:0]   trial_sub;
  logic                  ge;

  assign trial     = {rem_r, dq_r[Q_BITS-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    dq_nxt   = dq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[PRICE_BITS+Q_BITS-1:Q_BITS];
      dq_nxt   = num[Q_BITS-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
      dq_nxt  = {dq_r[Q_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(Q_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    dq_r  <= dq_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = dq_r;

  // The partial remainder must stay below the divisor for the quotient to fit.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rem_r < den_r)
    else $error("wpr_divider: partial remainder reached the divisor");

endmodule

`default_nettype wire

FILE: sv/williams_percent_r.sv
// Flow: an accepted item that gives a result passes ST_CALC, ST_MUL, the serial
//   divider when needed, and ST_DONE; a rescan runs ST_SCAN and ST_FIX first.
// Throughput: one item at a time; the serial divider and the rescan, with one
//   memory read per bar of the window, set the pace.
// Items with no result return to ST_IDLE, via ST_SCAN and ST_FIX on a rescan.
// Reset: synchronous, active low; cache, counters and control registers return to
//   reset values; datapath registers and the window memory keep their contents.
// ----------------------------------------------------------------------------
// williams_percent_r
// Sliding-window Williams %R over price bars with cached window extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module williams_percent_r import wpr_pkg::*; #(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire wpr_in_t              in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output wpr_out_t                  out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int ADDR_W = $clog2(MAX_PERIOD);
  localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
  localparam int SW     = CNT_W + 1;
  localparam int PB     = PRICE_BITS;
  localparam int IB     = FIELD_BITS;

  wpr_state_t state_r, state_nxt;

  logic [IB-1:0]       bars_seen_r, bars_seen_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic                hv_r, hv_nxt, lv_r, lv_nxt;
  logic [PB-1:0]       ch_r, ch_nxt, cl_r, cl_nxt;
  logic [IB-1:0]       hp_r, hp_nxt, lp_r, lp_nxt;

  logic [PB-1:0] hi_r, hi_nxt, lo_r, lo_nxt, close_r, close_nxt;
  logic          emit_r, emit_nxt, last_r, last_nxt;
  logic [IB-1:0] idx_r, idx_nxt;
  logic [PB-1:0] keep_h_r, keep_h_nxt, keep_l_r, keep_l_nxt;
  logic [IB-1:0] keep_hp_r, keep_hp_nxt, keep_lp_r, keep_lp_nxt;
  logic          hi_ok_r, hi_ok_nxt, lo_ok_r, lo_ok_nxt;

  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [IB-1:0]     rd_pos_r, rd_pos_nxt, dpos_r, dpos_nxt;
  logic              iss_r, iss_nxt, dv_r, dv_nxt, first_r, first_nxt;

  logic          flat_r, flat_nxt, zero_r, zero_nxt, sat_r, sat_nxt;
  logic [PB-1:0] range_r, range_nxt, diff_r, diff_nxt;

  logic     out_valid_r, out_valid_nxt;
  wpr_out_t out_item_r, out_item_nxt;

  // Per-item decode at the input.
  logic              acc;
  logic [PB-1:0]     hi_in, lo_in, close_in;
  logic [31:0]       p32;
  logic [CNT_W-1:0]  p_eff, pm1;
  logic              full;
  logic [IB-1:0]     trailing;
  logic [SW-1:0]     s_ext, d_ext;
  logic [ADDR_W-1:0] trail_slot;
  logic              hi_ok, lo_ok;
  logic [ADDR_W-1:0] slot_inc, rd_addr_inc;

  // Arithmetic for the result.
  logic [PB-1:0]        rng, diff;
  logic [PB:0]          sum;
  logic [PB+Q_BITS-1:0] prod;
  logic                 div_start;
  wpr_div_stat_t        div_stat;
  logic [PB-1:0]        scan_h, scan_l;
  logic [2*PB-1:0]      mem_rdata;

  assign acc      = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  assign hi_in    = PB'(in_item.high_price);
  assign lo_in    = PB'(in_item.low_price);
  assign close_in = PB'(in_item.close_price);

  assign p32 = (period_r == '0) ? 32'd1 :
               ((32'(period_r) > 32'(MAX_PERIOD)) ? 32'(MAX_PERIOD) : 32'(period_r));
  assign p_eff    = CNT_W'(p32);
  assign pm1      = p_eff - 1'b1;
  assign full     = ({1'b0, bars_seen_r} + 33'd1) >= 33'(p_eff);
  assign trailing = bars_seen_r - IB'(pm1);
  assign s_ext    = SW'(slot_r);
  assign d_ext    = SW'(pm1);
  assign trail_slot = (s_ext >= d_ext) ? ADDR_W'(s_ext - d_ext)
                                       : ADDR_W'(s_ext + SW'(MAX_PERIOD) - d_ext);
  assign hi_ok = hv_r && (hp_r >= trailing);
  assign lo_ok = lv_r && (lp_r >= trailing);

  assign slot_inc    = (slot_r == ADDR_W'(MAX_PERIOD - 1)) ? '0 : slot_r + 1'b1;
  assign rd_addr_inc = (rd_addr_r == ADDR_W'(MAX_PERIOD - 1)) ? '0 : rd_addr_r + 1'b1;

  assign scan_h = mem_rdata[2*PB-1:PB];
  assign scan_l = mem_rdata[PB-1:0];

  assign rng  = (ch_r >= cl_r) ? (ch_r - cl_r) : '0;
  assign sum  = {1'b0, ch_r} + {1'b0, cl_r};
  assign diff = ch_r - close_r;
  assign prod = (PB+Q_BITS)'(diff_r) * (PB+Q_BITS)'(FULL_SCALE);

  wpr_window_mem #(
    .DEPTH  (MAX_PERIOD),
    .ADDR_W (ADDR_W),
    .DATA_W (2 * PB)
  ) u_mem (
    .clk   (clk),
    .we    (acc),
    .waddr (slot_r),
    .wdata ({hi_in, lo_in}),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  wpr_divider #(
    .PRICE_BITS (PB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod),
    .den   (range_r),
    .stat  (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    bars_seen_nxt = bars_seen_r;
    slot_nxt      = slot_r;
    period_nxt    = period_r;
    shift_nxt     = shift_r;
    hv_nxt        = hv_r;
    lv_nxt        = lv_r;
    ch_nxt        = ch_r;
    cl_nxt        = cl_r;
    hp_nxt        = hp_r;
    lp_nxt        = lp_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    close_nxt     = close_r;
    emit_nxt      = emit_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    keep_h_nxt    = keep_h_r;
    keep_l_nxt    = keep_l_r;
    keep_hp_nxt   = keep_hp_r;
    keep_lp_nxt   = keep_lp_r;
    hi_ok_nxt     = hi_ok_r;
    lo_ok_nxt     = lo_ok_r;
    rd_addr_nxt   = rd_addr_r;
    rd_pos_nxt    = rd_pos_r;
    dpos_nxt      = dpos_r;
    iss_nxt       = iss_r;
    dv_nxt        = 1'b0;
    first_nxt     = first_r;
    flat_nxt      = flat_r;
    zero_nxt      = zero_r;
    sat_nxt       = sat_r;
    range_nxt     = range_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          hi_nxt    = hi_in;
          lo_nxt    = lo_in;
          close_nxt = close_in;
          emit_nxt  = in_item.emit_enable;
          last_nxt  = in_item.last_bar;
          idx_nxt   = bars_seen_r;
          bars_seen_nxt = in_item.last_bar ? '0 : bars_seen_r + 1'b1;
          slot_nxt      = in_item.last_bar ? '0 : slot_inc;
          if (!full) begin
            hv_nxt = 1'b0;
            lv_nxt = 1'b0;
          end else if (hi_ok && lo_ok) begin
            if (lo_in <= cl_r) begin
              cl_nxt = lo_in;
              lp_nxt = bars_seen_r;
            end
            if (hi_in >= ch_r) begin
              ch_nxt = hi_in;
              hp_nxt = bars_seen_r;
            end
            if (in_item.last_bar) begin
              hv_nxt = 1'b0;
              lv_nxt = 1'b0;
            end
            state_nxt = in_item.emit_enable ? ST_CALC : ST_IDLE;
          end else begin
            // A cached extreme left the window, so walk the whole window again.
            keep_h_nxt  = ch_r;
            keep_l_nxt  = cl_r;
            keep_hp_nxt = hp_r;
            keep_lp_nxt = lp_r;
            hi_ok_nxt   = hi_ok;
            lo_ok_nxt   = lo_ok;
            rd_addr_nxt = trail_slot;
            rd_pos_nxt  = trailing;
            iss_nxt     = 1'b1;
            first_nxt   = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_r) begin
          dv_nxt   = 1'b1;
          dpos_nxt = rd_pos_r;
          if (rd_pos_r == idx_r) begin
            iss_nxt = 1'b0;
          end else begin
            rd_pos_nxt  = rd_pos_r + 1'b1;
            rd_addr_nxt = rd_addr_inc;
          end
        end
        if (dv_r) begin
          if (first_r) begin
            ch_nxt    = scan_h;
            hp_nxt    = dpos_r;
            cl_nxt    = scan_l;
            lp_nxt    = dpos_r;
            first_nxt = 1'b0;
          end else begin
            if (scan_l < cl_r) begin
              cl_nxt = scan_l;
              lp_nxt = dpos_r;
            end
            if (scan_h > ch_r) begin
              ch_nxt = scan_h;
              hp_nxt = dpos_r;
            end
          end
          if (!iss_r) begin
            state_nxt = ST_FIX;
          end
        end
      end
      ST_FIX: begin
        // An extreme that stayed inside the window keeps its incremental rule.
        if (hi_ok_r) begin
          if (hi_r < keep_h_r) begin
            ch_nxt = keep_h_r;
            hp_nxt = keep_hp_r;
          end else begin
            ch_nxt = hi_r;
            hp_nxt = idx_r;
          end
        end
        if (lo_ok_r) begin
          if (lo_r > keep_l_r) begin
            cl_nxt = keep_l_r;
            lp_nxt = keep_lp_r;
          end else begin
            cl_nxt = lo_r;
            lp_nxt = idx_r;
          end
        end
        hv_nxt    = !last_r;
        lv_nxt    = !last_r;
        state_nxt = emit_r ? ST_CALC : ST_IDLE;
      end
      ST_CALC: begin
        range_nxt = rng;
        diff_nxt  = diff;
        flat_nxt  = {1'b0, rng} <= (sum >> shift_r);
        zero_nxt  = close_r >= ch_r;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        sat_nxt = diff_r > range_r;
        if (flat_r || zero_r || (diff_r > range_r)) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.flat_window = flat_r;
          out_item_nxt.bar_index   = idx_r;
          if (flat_r || zero_r) begin
            out_item_nxt.percent_r = '0;
          end else if (sat_r) begin
            out_item_nxt.percent_r = PCT_MIN;
          end else begin
            out_item_nxt.percent_r = $signed(16'd0 - {1'b0, div_stat.quotient});
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_PERIOD: begin
          period_nxt = cfg_data[PERIOD_W-1:0];
          hv_nxt     = 1'b0;
          lv_nxt     = 1'b0;
        end
        CFG_FLAT_SHIFT: begin
          shift_nxt = cfg_data[SHIFT_W-1:0];
        end
        default: begin
          shift_nxt = shift_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bars_seen_r <= '0;
      slot_r      <= '0;
      period_r    <= PERIOD_RESET;
      shift_r     <= SHIFT_RESET;
      hv_r        <= 1'b0;
      lv_r        <= 1'b0;
      ch_r        <= '0;
      cl_r        <= '0;
      hp_r        <= '0;
      lp_r        <= '0;
      iss_r       <= 1'b0;
      dv_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bars_seen_r <= bars_seen_nxt;
      slot_r      <= slot_nxt;
      period_r    <= period_nxt;
      shift_r     <= shift_nxt;
      hv_r        <= hv_nxt;
      lv_r        <= lv_nxt;
      ch_r        <= ch_nxt;
      cl_r        <= cl_nxt;
      hp_r        <= hp_nxt;
      lp_r        <= lp_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    close_r   <= close_nxt;
    emit_r    <= emit_nxt;
    last_r    <= last_nxt;
    idx_r     <= idx_nxt;
    keep_h_r  <= keep_h_nxt;
    keep_l_r  <= keep_l_nxt;
    keep_hp_r <= keep_hp_nxt;
    keep_lp_r <= keep_lp_nxt;
    hi_ok_r   <= hi_ok_nxt;
    lo_ok_r   <= lo_ok_nxt;
    rd_addr_r <= rd_addr_nxt;
    rd_pos_r  <= rd_pos_nxt;
    dpos_r    <= dpos_nxt;
    flat_r    <= flat_nxt;
    zero_r    <= zero_nxt;
    sat_r     <= sat_nxt;
    range_r   <= range_nxt;
    diff_r    <= diff_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The rescan never reads past the bar that started it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && iss_r |-> rd_pos_r <= idx_r)
    else $error("williams_percent_r: rescan ran past the current bar");

  // Results stay inside the saturation range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.percent_r <= 16'sd0) && (out_item_r.percent_r >= PCT_MIN))
    else $error("williams_percent_r: percent_r out of range");

  // A flat window always reports zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.flat_window |-> out_item_r.percent_r == 16'sd0)
    else $error("williams_percent_r: flat window with nonzero percent_r");

  // Both cached extremes are revalidated together when a rescan finishes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX) |=> hv_r == lv_r)
    else $error("williams_percent_r: extreme valid flags disagree after rescan");

endmodule

`default_nettype wire
